### rtl/ffsc_pkg.sv
package ffsc_pkg;

    localparam int unsigned SetPoints = 5;
    localparam int unsigned FracBits  = 16;
    localparam int unsigned WidthW    = 18;
    localparam int unsigned WeightW   = 16;
    localparam int unsigned PctW      = 7;
    localparam int unsigned CfgIdxW   = 3;
    localparam int unsigned CfgDataW  = 18;

    localparam logic [CfgIdxW-1:0] CFG_TEMP_WIDTH   = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_GAS_WIDTH    = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_LIGHT_WIDTH  = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_TEMP_WEIGHT  = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_GAS_WEIGHT   = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_LIGHT_WEIGHT = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_STOP_PERCENT = 3'd6;
    localparam logic [CfgIdxW-1:0] CFG_HIGH_PERCENT = 3'd7;

    localparam logic [1:0] MODE_STOP    = 2'd0;
    localparam logic [1:0] MODE_PERCENT = 2'd1;
    localparam logic [1:0] MODE_HIGH    = 2'd2;

    typedef struct packed {
        logic signed [11:0] temp_reading;
        logic               temp_present;
        logic [13:0]        gas_level;
        logic [17:0]        light_level;
    } ffsc_in_t;

    typedef struct packed {
        logic       motor_enable;
        logic [7:0] pwm_duty;
        logic [7:0] speed_value;
        logic [6:0] speed_percent;
        logic [1:0] display_mode;
    } ffsc_out_t;

    // set point of input k (0 temp, 1 gas, 2 light) at index i, as signed 19 bit
    function automatic logic signed [18:0] set_point(input logic [1:0] k,
                                                     input logic [3:0] i);
        logic signed [18:0] p;
        p = '0;
        case (k)
            2'd0:
                case (i)
                    4'd0: p = -19'sd55;
                    4'd1: p = 19'sd0;
                    4'd2: p = 19'sd30;
                    4'd3: p = 19'sd80;
                    default: p = 19'sd125;
                endcase
            2'd1:
                case (i)
                    4'd0: p = 19'sd10;
                    4'd1: p = 19'sd2500;
                    4'd2: p = 19'sd5000;
                    4'd3: p = 19'sd7500;
                    default: p = 19'sd10000;
                endcase
            default:
                case (i)
                    4'd0: p = 19'sd0;
                    4'd1: p = 19'sd32500;
                    4'd2: p = 19'sd65000;
                    4'd3: p = 19'sd97500;
                    default: p = 19'sd130000;
                endcase
        endcase
        return p;
    endfunction

    function automatic logic [7:0] speed_point(input logic [3:0] j);
        logic [7:0] s;
        case (j)
            4'd0: s = 8'd0;
            4'd1: s = 8'd50;
            4'd2: s = 8'd127;
            4'd3: s = 8'd200;
            default: s = 8'd255;
        endcase
        return s;
    endfunction

    function automatic logic [15:0] relation(input logic [3:0] i, input logic [3:0] j);
        logic [15:0] r;
        r = '0;
        case ({i[2:0], j[2:0]})
            {3'd0, 3'd0}: r = 16'd6554; {3'd0, 3'd1}: r = 16'd6554;
            {3'd0, 3'd2}: r = 16'd1428; {3'd0, 3'd3}: r = 16'd512;
            {3'd0, 3'd4}: r = 16'd301;
            {3'd1, 3'd0}: r = 16'd5797; {3'd1, 3'd1}: r = 16'd5797;
            {3'd1, 3'd2}: r = 16'd3277; {3'd1, 3'd3}: r = 16'd2993;
            {3'd1, 3'd4}: r = 16'd1004;
            {3'd2, 3'd0}: r = 16'd6554; {3'd2, 3'd1}: r = 16'd6554;
            {3'd2, 3'd2}: r = 16'd6554; {3'd2, 3'd3}: r = 16'd4033;
            {3'd2, 3'd4}: r = 16'd4033;
            {3'd3, 3'd0}: r = 16'd3277; {3'd3, 3'd1}: r = 16'd3277;
            {3'd3, 3'd2}: r = 16'd3277; {3'd3, 3'd3}: r = 16'd3277;
            {3'd3, 3'd4}: r = 16'd3277;
            {3'd4, 3'd0}: r = 16'd256;  {3'd4, 3'd1}: r = 16'd395;
            {3'd4, 3'd2}: r = 16'd1004; {3'd4, 3'd3}: r = 16'd5095;
            {3'd4, 3'd4}: r = 16'd6554;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

### rtl/ffsc_if.sv
interface ffsc_if #(
    parameter int unsigned W = 1
);
    logic         valid;
    logic         ready;
    logic [W-1:0] payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### rtl/fuzzy_fan_speed_controller_unit.sv
// Channel  Dir  Payload                                              Handshake
// in_ch    in   temp_reading, temp_present, gas_level, light_level   valid/ready
// out_ch   out  motor_enable, pwm_duty, speed_value, speed_percent,  valid/ready
//               display_mode
// cfg      in   cfg_we, cfg_index, cfg_data                          write strobe
//
// One item at a time. Each of the 15 memberships passes through a start
// state, a 33-step serial divide, a 16-step serial multiply and a write
// state; a zero membership skips the divide and multiply. Composition
// walks all 25 row/column pairs, then come the centroid and percent divides
// (the centroid divide is skipped on a zero sum). All divides share one
// bit-serial divider, and all memberships share one bit-serial multiplier.
// Reset clears held values, last duty and loads the register defaults. A
// stalled result holds in the output register; in_ch.ready stays low until
// the result has been taken.
module fuzzy_fan_speed_controller_unit
    import ffsc_pkg::*;
#(
    parameter int unsigned FRAC_BITS  = FracBits
) (
    input  logic                clk,
    input  logic                rst_n,
    ffsc_if.sink                in_ch,
    ffsc_if.source              out_ch,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);
    localparam int unsigned IdxW  = $clog2(SetPoints);
    localparam int unsigned MuW   = FRAC_BITS + 1;       // weighted mu < 2^FRAC_BITS
    localparam int unsigned S1W   = MuW + 8 + IdxW + 1;
    localparam int unsigned S2W   = MuW + IdxW + 1;
    localparam int unsigned DivNW = (S1W > 33) ? S1W : 33;
    localparam int unsigned DivDW = (S2W > WidthW) ? S2W : WidthW;
    localparam int unsigned PShift = 31 - FRAC_BITS;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_FDIV  = 9'b000000010,
        ST_FWAIT = 9'b000000100,
        ST_FMUL  = 9'b000001000,
        ST_MWAIT = 9'b000010000,
        ST_COMP  = 9'b000100000,
        ST_CDIV  = 9'b001000000,
        ST_PDIV  = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [WidthW-1:0]  wid_reg [3];
    logic [WeightW-1:0] wgt_reg [3];
    logic [PctW-1:0]    stop_reg, high_reg;

    // held samples
    logic signed [11:0] ht_reg;
    logic [13:0]        hg_reg;
    logic [17:0]        hl_reg;
    logic [7:0]         last_duty_reg;

    // combined set
    logic [MuW-1:0] cs_reg [SetPoints];
    logic [MuW-1:0] best_reg;
    logic [1:0]     k_reg;
    logic [IdxW-1:0] i_reg, j_reg;
    logic [S1W-1:0] s1_reg;
    logic [S2W-1:0] s2_reg;
    logic [7:0]     speed_reg;
    ffsc_out_t      res_reg;
    logic           out_valid_reg;
    ffsc_in_t       in_item;

    // current membership operands
    logic signed [18:0] val;
    logic signed [19:0] diff;
    logic [18:0]        gap_abs;
    logic [WidthW-1:0]  w_cur;
    logic               mu_zero;
    logic [WidthW:0]    twice_gap;
    logic [MuW-1:0]     wmu;
    logic [MuW-1:0]     r_al;
    logic [MuW-1:0]     vmin;
    logic [MuW-1:0]     cs_new;

    logic             d_start, d_busy, d_done;
    logic [DivNW-1:0] d_numer, d_quot;
    logic [DivDW-1:0] d_denom;
    logic            m_start, m_done;
    logic [31:0]     m_prod;
    logic            mu_zero_reg;

    assign in_item = ffsc_in_t'(in_ch.payload);

    ffsc_div #(.NW(DivNW), .DW(DivDW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(d_start), .numer(d_numer),
        .denom(d_denom), .busy(d_busy), .done(d_done), .quot(d_quot)
    );

    // multiply the fresh quotient as it appears on the divider's done cycle
    ffsc_mul #(.AW(16), .BW(16)) u_mul (
        .clk(clk), .rst_n(rst_n), .start(m_start), .a(d_quot[15:0]),
        .b(wgt_reg[k_reg]), .done(m_done), .prod(m_prod)
    );

    always_comb
    begin
        unique case (k_reg)
            2'd0:    val = 19'(ht_reg);
            2'd1:    val = {5'd0, hg_reg};
            default: val = {1'b0, hl_reg};
        endcase
        diff      = 20'(val) - 20'(set_point(k_reg, 4'(i_reg)));
        gap_abs   = diff[19] ? 19'(-diff) : diff[18:0];
        w_cur     = wid_reg[k_reg];
        mu_zero   = (w_cur == '0) || (gap_abs > 19'(w_cur >> 1));
        twice_gap = 19'(w_cur) - 19'({gap_abs[17:0], 1'b0});
        wmu       = mu_zero_reg ? '0 : MuW'(m_prod >> PShift);
        r_al      = MuW'((32'(relation(4'(i_reg), 4'(j_reg))) << 8) >> (24 - FRAC_BITS));
        vmin      = (cs_reg[i_reg] < r_al) ? cs_reg[i_reg] : r_al;
        cs_new    = (k_reg == 2'd0 || wmu < cs_reg[i_reg]) ? wmu : cs_reg[i_reg];
    end

    // divider operand selection and multiplier start
    always_comb
    begin
        d_start = 1'b0;
        d_numer = '0;
        d_denom = '0;
        m_start = 1'b0;
        unique case (state_reg)
            ST_FDIV:
            begin
                d_start = !mu_zero;
                d_numer = DivNW'({twice_gap[WidthW-1:0], 15'd0});
                d_denom = DivDW'(w_cur);
            end
            ST_CDIV:
            begin
                d_numer = DivNW'(s1_reg);
                d_denom = DivDW'(s2_reg);
                d_start = (s2_reg != '0) && !d_busy && !d_done;
            end
            ST_PDIV:
            begin
                d_numer = DivNW'(16'(speed_reg) * 16'd100 + 16'd254);
                d_denom = DivDW'(8'd255);
                d_start = !d_busy && !d_done;
            end
            ST_FWAIT: m_start = d_done;
            default: ;
        endcase
    end

    logic acc;
    assign acc = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE) && !out_valid_reg;

    logic [7:0] pct_w;
    assign pct_w = d_quot[7:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (acc) state_next = ST_FDIV;
            ST_FDIV:  state_next = mu_zero ? ST_MWAIT : ST_FWAIT;
            ST_FWAIT: if (d_done) state_next = ST_FMUL;
            ST_FMUL:  if (m_done) state_next = ST_MWAIT;
            ST_MWAIT:
                if (i_reg == IdxW'(SetPoints - 1) && k_reg == 2'd2) state_next = ST_COMP;
                else state_next = ST_FDIV;
            ST_COMP:
                if (i_reg == IdxW'(SetPoints - 1) && j_reg == IdxW'(SetPoints - 1))
                    state_next = ST_CDIV;
            ST_CDIV:
                if (s2_reg == '0 || d_done) state_next = ST_PDIV;
            ST_PDIV:  if (d_done) state_next = ST_OUT;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wid_reg[0]    <= 18'd180;
            wid_reg[1]    <= 18'd9000;
            wid_reg[2]    <= 18'd130000;
            wgt_reg[0]    <= 16'd26214;
            wgt_reg[1]    <= 16'd32768;
            wgt_reg[2]    <= 16'd6554;
            stop_reg      <= 7'd10;
            high_reg      <= 7'd80;
            ht_reg        <= '0;
            hg_reg        <= '0;
            hl_reg        <= '0;
            last_duty_reg <= '0;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TEMP_WIDTH:   wid_reg[0] <= cfg_data;
                    CFG_GAS_WIDTH:    wid_reg[1] <= cfg_data;
                    CFG_LIGHT_WIDTH:  wid_reg[2] <= cfg_data;
                    CFG_TEMP_WEIGHT:  wgt_reg[0] <= cfg_data[WeightW-1:0];
                    CFG_GAS_WEIGHT:   wgt_reg[1] <= cfg_data[WeightW-1:0];
                    CFG_LIGHT_WEIGHT: wgt_reg[2] <= cfg_data[WeightW-1:0];
                    CFG_STOP_PERCENT: stop_reg <= cfg_data[PctW-1:0];
                    CFG_HIGH_PERCENT: high_reg <= cfg_data[PctW-1:0];
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                    if (acc)
                    begin
                        // hold last in-range sample of each sensor
                        if (in_item.temp_present
                            && in_item.temp_reading >= -12'sd55
                            && in_item.temp_reading <= 12'sd125)
                            ht_reg <= in_item.temp_reading;
                        if (in_item.gas_level >= 14'd10
                            && in_item.gas_level <= 14'd10000)
                            hg_reg <= in_item.gas_level;
                        if (in_item.light_level <= 18'd130000)
                            hl_reg <= in_item.light_level;
                        k_reg <= '0;
                        i_reg <= '0;
                    end
                ST_MWAIT:
                    if (i_reg == IdxW'(SetPoints - 1))
                    begin
                        i_reg <= '0;
                        j_reg <= '0;
                        if (k_reg != 2'd2) k_reg <= k_reg + 2'd1;
                    end
                    else i_reg <= i_reg + 1'b1;
                ST_COMP:
                    if (i_reg == IdxW'(SetPoints - 1))
                    begin
                        i_reg <= '0;
                        j_reg <= j_reg + 1'b1;
                    end
                    else i_reg <= i_reg + 1'b1;
                ST_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    if (res_reg.display_mode != MODE_STOP)
                        last_duty_reg <= res_reg.pwm_duty;
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                s1_reg   <= '0;
                s2_reg   <= '0;
                best_reg <= '0;
            end
            // a membership outside its triangle skips the divide and reads as zero
            ST_FDIV: mu_zero_reg <= mu_zero;
            ST_MWAIT:
                cs_reg[i_reg] <= cs_new;
            ST_COMP:
            begin
                // max over rows, then accumulate the column into the centroid sums
                if (i_reg == IdxW'(SetPoints - 1))
                begin
                    s1_reg <= s1_reg + S1W'(((vmin > best_reg) ? vmin : best_reg)
                              * speed_point(4'(j_reg)));
                    s2_reg <= s2_reg + S2W'((vmin > best_reg) ? vmin : best_reg);
                    best_reg <= '0;
                end
                else if (vmin > best_reg) best_reg <= vmin;
            end
            ST_CDIV:
                if (s2_reg == '0) speed_reg <= '0;
                else if (d_done) speed_reg <= d_quot[7:0];
            ST_PDIV:
                if (d_done)
                begin
                    res_reg.speed_value   <= speed_reg;
                    res_reg.speed_percent <= pct_w[6:0];
                    if (pct_w[6:0] < stop_reg)
                    begin
                        res_reg.motor_enable <= 1'b0;
                        res_reg.pwm_duty     <= last_duty_reg;
                        res_reg.display_mode <= MODE_STOP;
                    end
                    else if (pct_w[6:0] <= high_reg)
                    begin
                        res_reg.motor_enable <= 1'b1;
                        res_reg.pwm_duty     <= speed_reg;
                        res_reg.display_mode <= MODE_PERCENT;
                    end
                    else
                    begin
                        res_reg.motor_enable <= 1'b1;
                        res_reg.pwm_duty     <= 8'hFF;
                        res_reg.display_mode <= MODE_HIGH;
                    end
                end
            default: ;
        endcase
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = res_reg;

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> (state_reg == ST_IDLE))
        else $error("input ready outside idle");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> $stable(out_ch.payload))
        else $error("result changed while stalled");
    a_stop_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (res_reg.motor_enable
                          == (res_reg.display_mode != MODE_STOP)))
        else $error("enable disagrees with mode");
endmodule

### rtl/ffsc_div.sv
// Restoring divider, one quotient bit per cycle.
module ffsc_div #(
    parameter int unsigned NW = 32,
    parameter int unsigned DW = 24
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] numer,
    input  logic [DW-1:0] denom,
    output logic          busy,
    output logic          done,
    output logic [NW-1:0] quot
);
    localparam int unsigned CntW = $clog2(NW + 1);

    logic [NW-1:0]   q_reg, q_next;
    logic [DW:0]     r_reg, r_next;
    logic [DW-1:0]   d_reg, d_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next, done_reg, done_next;
    logic [DW+1:0]   trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (start)
        begin
            q_next    = numer;
            r_next    = '0;
            d_next    = denom;
            cnt_next  = CntW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in next numerator bit, subtract if it fits
            trial = {r_reg, q_reg[NW-1]} - {2'b00, d_reg};
            if (!trial[DW+1])
            begin
                r_next = trial[DW:0];
                q_next = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[DW-1:0], q_reg[NW-1]};
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = q_reg;
endmodule

### rtl/ffsc_mul.sv
// Shift-add multiplier, one multiplier bit per cycle.
module ffsc_mul #(
    parameter int unsigned AW = 16,
    parameter int unsigned BW = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic             done,
    output logic [AW+BW-1:0] prod
);
    localparam int unsigned CntW = $clog2(BW + 1);

    logic [AW+BW-1:0] acc_reg, acc_next;
    logic [AW-1:0]    a_reg, a_next;
    logic [BW-1:0]    b_reg, b_next;
    logic [CntW-1:0]  cnt_reg, cnt_next;
    logic             busy_reg, busy_next, done_reg, done_next;

    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            a_next    = a;
            b_next    = b;
            cnt_next  = CntW'(BW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // msb first: double then add
            acc_next = {acc_reg[AW+BW-2:0], 1'b0}
                       + (b_reg[BW-1] ? {{BW{1'b0}}, a_reg} : '0);
            b_next   = {b_reg[BW-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;
endmodule
